// ----- src/sprite_quad_vertex_transform_macros.svh -----
// ----------------------------------------------------------------------------
// sprite quad vertex transform assertion macros
// shared concurrent assertion wrappers for the block's rtl
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_VERTEX_TRANSFORM_MACROS_SVH
`define SPRITE_QUAD_VERTEX_TRANSFORM_MACROS_SVH

// checked only outside reset
`define SVT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked at every edge, reset included
`define SVT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/svt_pkg.sv -----
// ----------------------------------------------------------------------------
// svt_pkg
// widths, codes, arctangent table and helpers of the sprite quad transform
// ----------------------------------------------------------------------------
package svt_pkg;

   // field widths
   localparam int POS_W      = 24;
   localparam int SCALE_W    = 16;
   localparam int ANGLE_W    = 16;
   localparam int ACT_W      = 2;
   localparam int SIZE_W     = 12;
   localparam int MODE_W     = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CORNERS    = 4;
   localparam int OUT_W      = 2 * CORNERS * POS_W;

   // internal widths
   localparam int OFS_W     = SIZE_W + 1;           // edge offset in pixels
   localparam int SOFS_W    = OFS_W + SCALE_W;      // scaled or shifted offset
   localparam int CORD_W    = 32;                   // cordic q2.30 datapath
   localparam int TRIG_FRAC = 14;
   localparam int TRIG_W    = CORD_W + 1 - 16;      // rounded cos / sin
   localparam int PROD_W    = SOFS_W + TRIG_W;      // offset times trig
   localparam int RT_W      = PROD_W + 1 - TRIG_FRAC;
   localparam int SUM_W     = RT_W + 2;
   localparam int ATAN_N    = 24;
   localparam int ATAN_IDX_W = 5;

   // action codes
   localparam logic [ACT_W-1:0] ACT_MOVE   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_SCALE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_ROTATE = 2'd2;

   // anchor mode codes
   localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CENTER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_XMODE  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_YMODE  = 2'd3;

   // cordic start value (inverse gain) and rounding constants
   localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [CORD_W:0]   TRIG_HALF   = 33'sd32768;
   localparam logic signed [PROD_W:0]   PROD_HALF   = 47'sd8192;
   localparam logic signed [SUM_W-1:0]  SUM_POS_MAX = 35'sd8388607;
   localparam logic signed [SUM_W-1:0]  SUM_POS_MIN = -35'sd8388608;

   // item data that rides alongside the cordic
   typedef struct packed {
      logic                     rot;
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [SOFS_W-1:0] u0;
      logic signed [SOFS_W-1:0] u1;
      logic signed [SOFS_W-1:0] v0;
      logic signed [SOFS_W-1:0] v1;
   } svt_side_type;

   // arctangent of 2^-i in 2^-32 turn units
   function automatic logic [CORD_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [CORD_W-1:0] r;
      case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051D;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2F;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2F9;
         5'd15:   r = 32'h0000517C;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A2F;
         5'd19:   r = 32'h00000517;
         5'd20:   r = 32'h0000028B;
         5'd21:   r = 32'h00000145;
         5'd22:   r = 32'h000000A2;
         5'd23:   r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

   // clamp a wide sum to the signed 24 bit coordinate range
   function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
      logic [POS_W-1:0] r;
      if (v > SUM_POS_MAX) begin
         r = SUM_POS_MAX[POS_W-1:0];
      end else if (v < SUM_POS_MIN) begin
         r = SUM_POS_MIN[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- src/svt_prep.sv -----
// ----------------------------------------------------------------------------
// svt_prep
// config registers, edge offsets, angle folding and offset scaling (2 stages)
// ----------------------------------------------------------------------------
module svt_prep #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // register writes
   input  logic                                  csr_we,
   input  logic [svt_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [svt_pkg::SIZE_W-1:0]            csr_wdata,
   // incoming words
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [svt_pkg::ACT_W-1:0]             in_action,
   input  logic signed [svt_pkg::POS_W-1:0]      in_pos_x,
   input  logic signed [svt_pkg::POS_W-1:0]      in_pos_y,
   input  logic signed [svt_pkg::SCALE_W-1:0]    in_scale_x,
   input  logic signed [svt_pkg::SCALE_W-1:0]    in_scale_y,
   input  logic [svt_pkg::ANGLE_W-1:0]           in_angle,
   // to the cordic
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output svt_pkg::svt_side_type                 out_side,
   output logic signed [svt_pkg::CORD_W-1:0]     out_z,
   output logic                                  out_flip
);

   // configuration registers
   logic [svt_pkg::SIZE_W-1:0] width_ff;
   logic [svt_pkg::SIZE_W-1:0] height_ff;
   logic [svt_pkg::MODE_W-1:0] xmode_ff;
   logic [svt_pkg::MODE_W-1:0] ymode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         xmode_ff  <= svt_pkg::MODE_START;
         ymode_ff  <= svt_pkg::MODE_START;
      end else if (csr_we) begin
         case (csr_addr)
            svt_pkg::CSR_WIDTH:  width_ff  <= csr_wdata;
            svt_pkg::CSR_HEIGHT: height_ff <= csr_wdata;
            svt_pkg::CSR_XMODE:  xmode_ff  <= csr_wdata[svt_pkg::MODE_W-1:0];
            svt_pkg::CSR_YMODE:  ymode_ff  <= csr_wdata[svt_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   // anchor offsets inside the sprite
   logic [svt_pkg::SIZE_W-1:0] ox;
   logic [svt_pkg::SIZE_W-1:0] oy;

   always_comb begin
      case (xmode_ff)
         svt_pkg::MODE_CENTER: ox = width_ff >> 1;
         svt_pkg::MODE_END:    ox = width_ff;
         default:              ox = '0;
      endcase
      case (ymode_ff)
         svt_pkg::MODE_CENTER: oy = height_ff >> 1;
         svt_pkg::MODE_END:    oy = height_ff;
         default:              oy = '0;
      endcase
   end

   // stage handshake
   logic v1_ff;
   logic v2_ff;
   logic en1;
   logic en2;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1 next values: offsets, action decode, folded angle
   logic signed [svt_pkg::OFS_W-1:0]  u0_in, u1_in, v0_in, v1_in;
   logic                              scl_in, rot_in, flip_in;
   logic signed [svt_pkg::CORD_W-1:0] z_in;

   always_comb begin
      u0_in   = $signed(svt_pkg::OFS_W'(0) - {1'b0, ox});
      u1_in   = $signed({1'b0, width_ff} - {1'b0, ox});
      v0_in   = $signed(svt_pkg::OFS_W'(0) - {1'b0, oy});
      v1_in   = $signed({1'b0, height_ff} - {1'b0, oy});
      scl_in  = (in_action == svt_pkg::ACT_SCALE) || (in_action == svt_pkg::ACT_ROTATE);
      rot_in  = (in_action == svt_pkg::ACT_ROTATE);
      // second or third quarter turn: step back half a turn, negate later
      flip_in = in_angle[svt_pkg::ANGLE_W-1] ^ in_angle[svt_pkg::ANGLE_W-2];
      z_in    = $signed({in_angle[svt_pkg::ANGLE_W-1] ^ flip_in,
                         in_angle[svt_pkg::ANGLE_W-2:0],
                         {(svt_pkg::CORD_W - svt_pkg::ANGLE_W){1'b0}}});
   end

   // stage 1 registers
   logic signed [svt_pkg::OFS_W-1:0]   s1_u0_ff, s1_u1_ff, s1_v0_ff, s1_v1_ff;
   logic signed [svt_pkg::SCALE_W-1:0] s1_sx_ff, s1_sy_ff;
   logic signed [svt_pkg::POS_W-1:0]   s1_px_ff, s1_py_ff;
   logic                               s1_scl_ff, s1_rot_ff, s1_flip_ff;
   logic signed [svt_pkg::CORD_W-1:0]  s1_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_u0_ff   <= u0_in;
         s1_u1_ff   <= u1_in;
         s1_v0_ff   <= v0_in;
         s1_v1_ff   <= v1_in;
         s1_sx_ff   <= in_scale_x;
         s1_sy_ff   <= in_scale_y;
         s1_px_ff   <= in_pos_x;
         s1_py_ff   <= in_pos_y;
         s1_scl_ff  <= scl_in;
         s1_rot_ff  <= rot_in;
         s1_flip_ff <= flip_in;
         s1_z_ff    <= z_in;
      end
   end

   // stage 2 next values: scale by the item's factors or shift to fixed point
   logic signed [svt_pkg::SOFS_W-1:0] u0_sc, u1_sc, v0_sc, v1_sc;

   always_comb begin
      if (s1_scl_ff) begin
         u0_sc = s1_u0_ff * s1_sx_ff;
         u1_sc = s1_u1_ff * s1_sx_ff;
         v0_sc = s1_v0_ff * s1_sy_ff;
         v1_sc = s1_v1_ff * s1_sy_ff;
      end else begin
         u0_sc = svt_pkg::SOFS_W'(s1_u0_ff) <<< FRAC_BITS;
         u1_sc = svt_pkg::SOFS_W'(s1_u1_ff) <<< FRAC_BITS;
         v0_sc = svt_pkg::SOFS_W'(s1_v0_ff) <<< FRAC_BITS;
         v1_sc = svt_pkg::SOFS_W'(s1_v1_ff) <<< FRAC_BITS;
      end
   end

   // stage 2 registers
   svt_pkg::svt_side_type             s2_side_ff;
   logic signed [svt_pkg::CORD_W-1:0] s2_z_ff;
   logic                              s2_flip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_side_ff.rot <= s1_rot_ff;
         s2_side_ff.px  <= s1_px_ff;
         s2_side_ff.py  <= s1_py_ff;
         s2_side_ff.u0  <= u0_sc;
         s2_side_ff.u1  <= u1_sc;
         s2_side_ff.v0  <= v0_sc;
         s2_side_ff.v1  <= v1_sc;
         s2_z_ff        <= s1_z_ff;
         s2_flip_ff     <= s1_flip_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_side  = s2_side_ff;
   assign out_z     = s2_z_ff;
   assign out_flip  = s2_flip_ff;

endmodule

// ----- src/svt_cordic.sv -----
// ----------------------------------------------------------------------------
// svt_cordic
// rotation-mode cordic, one register stage per iteration, side data in tow
// ----------------------------------------------------------------------------
module svt_cordic #(
   parameter int STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  svt_pkg::svt_side_type             in_side,
   input  logic signed [svt_pkg::CORD_W-1:0] in_z,
   input  logic                              in_flip,
   output logic                              out_valid,
   input  logic                              out_ready,
   output svt_pkg::svt_side_type             out_side,
   output logic signed [svt_pkg::CORD_W-1:0] out_x,
   output logic signed [svt_pkg::CORD_W-1:0] out_y,
   output logic                              out_flip
);

   // stage registers
   logic [STEPS-1:0]                  v_ff;
   logic signed [svt_pkg::CORD_W-1:0] x_ff    [STEPS];
   logic signed [svt_pkg::CORD_W-1:0] y_ff    [STEPS];
   logic signed [svt_pkg::CORD_W-1:0] z_ff    [STEPS];
   logic                              flip_ff [STEPS];
   svt_pkg::svt_side_type             side_ff [STEPS];

   // stage inputs and next values
   logic signed [svt_pkg::CORD_W-1:0] x_src [STEPS];
   logic signed [svt_pkg::CORD_W-1:0] y_src [STEPS];
   logic signed [svt_pkg::CORD_W-1:0] z_src [STEPS];
   logic signed [svt_pkg::CORD_W-1:0] x_in  [STEPS];
   logic signed [svt_pkg::CORD_W-1:0] y_in  [STEPS];
   logic signed [svt_pkg::CORD_W-1:0] z_in  [STEPS];
   logic signed [svt_pkg::CORD_W-1:0] atan_v [STEPS];

   // per-stage load enables, ready flows back stage by stage
   logic [STEPS:0] en;

   assign en[STEPS] = out_ready;
   for (genvar g = 0; g < STEPS; g++) begin : g_en
      assign en[g] = !v_ff[g] || en[g+1];
   end
   assign in_ready = en[0];

   // one micro-rotation per stage
   always_comb begin
      x_src[0] = svt_pkg::CORDIC_GAIN;
      y_src[0] = '0;
      z_src[0] = in_z;
      for (int i = 1; i < STEPS; i++) begin
         x_src[i] = x_ff[i-1];
         y_src[i] = y_ff[i-1];
         z_src[i] = z_ff[i-1];
      end
      for (int i = 0; i < STEPS; i++) begin
         atan_v[i] = $signed(svt_pkg::atan_turn(svt_pkg::ATAN_IDX_W'(i)));
         if (!z_src[i][svt_pkg::CORD_W-1]) begin
            x_in[i] = x_src[i] - (y_src[i] >>> i);
            y_in[i] = y_src[i] + (x_src[i] >>> i);
            z_in[i] = z_src[i] - atan_v[i];
         end else begin
            x_in[i] = x_src[i] + (y_src[i] >>> i);
            y_in[i] = y_src[i] - (x_src[i] >>> i);
            z_in[i] = z_src[i] + atan_v[i];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < STEPS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en[0]) begin
         flip_ff[0] <= in_flip;
         side_ff[0] <= in_side;
      end
      for (int i = 1; i < STEPS; i++) begin
         if (en[i]) begin
            flip_ff[i] <= flip_ff[i-1];
            side_ff[i] <= side_ff[i-1];
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         if (en[i]) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];
   assign out_x     = x_ff[STEPS-1];
   assign out_y     = y_ff[STEPS-1];
   assign out_flip  = flip_ff[STEPS-1];

endmodule

// ----- src/svt_rotate.sv -----
// ----------------------------------------------------------------------------
// svt_rotate
// trig rounding, offset products, corner sums with saturation (3 stages)
// ----------------------------------------------------------------------------
`include "sprite_quad_vertex_transform_macros.svh"

module svt_rotate (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  svt_pkg::svt_side_type             in_side,
   input  logic signed [svt_pkg::CORD_W-1:0] in_x,
   input  logic signed [svt_pkg::CORD_W-1:0] in_y,
   input  logic                              in_flip,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [svt_pkg::OUT_W-1:0]         out_data
);

   // stage handshake
   logic [2:0] v_ff;
   logic [3:0] en;

   assign en[3] = out_ready;
   for (genvar g = 0; g < 3; g++) begin : g_en
      assign en[g] = !v_ff[g] || en[g+1];
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         if (en[1]) v_ff[1] <= v_ff[0];
         if (en[2]) v_ff[2] <= v_ff[1];
      end
   end

   // stage a: undo the half-turn fold and round to 14 fraction bits
   logic signed [svt_pkg::CORD_W:0]   xf, yf, xr, yr;
   logic signed [svt_pkg::TRIG_W-1:0] c_ff, s_ff;
   svt_pkg::svt_side_type             side_a_ff;

   always_comb begin
      xf = in_flip ? -{in_x[svt_pkg::CORD_W-1], in_x} : {in_x[svt_pkg::CORD_W-1], in_x};
      yf = in_flip ? -{in_y[svt_pkg::CORD_W-1], in_y} : {in_y[svt_pkg::CORD_W-1], in_y};
      xr = xf + svt_pkg::TRIG_HALF;
      yr = yf + svt_pkg::TRIG_HALF;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         c_ff      <= xr[svt_pkg::CORD_W:svt_pkg::CORD_W+1-svt_pkg::TRIG_W];
         s_ff      <= yr[svt_pkg::CORD_W:svt_pkg::CORD_W+1-svt_pkg::TRIG_W];
         side_a_ff <= in_side;
      end
   end

   // stage b: every offset times cos and sin; order u0 u1 v0 v1
   logic signed [svt_pkg::SOFS_W-1:0] ofs_a [svt_pkg::CORNERS];
   logic signed [svt_pkg::PROD_W-1:0] pc_ff [svt_pkg::CORNERS];
   logic signed [svt_pkg::PROD_W-1:0] ps_ff [svt_pkg::CORNERS];
   svt_pkg::svt_side_type             side_b_ff;

   assign ofs_a[0] = side_a_ff.u0;
   assign ofs_a[1] = side_a_ff.u1;
   assign ofs_a[2] = side_a_ff.v0;
   assign ofs_a[3] = side_a_ff.v1;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int k = 0; k < svt_pkg::CORNERS; k++) begin
            pc_ff[k] <= ofs_a[k] * c_ff;
            ps_ff[k] <= ofs_a[k] * s_ff;
         end
         side_b_ff <= side_a_ff;
      end
   end

   // stage c: round products, add the anchor, saturate
   logic signed [svt_pkg::SOFS_W-1:0] ofs_b [svt_pkg::CORNERS];
   logic signed [svt_pkg::PROD_W:0]   rnd_c [svt_pkg::CORNERS];
   logic signed [svt_pkg::PROD_W:0]   rnd_s [svt_pkg::CORNERS];
   logic signed [svt_pkg::RT_W-1:0]   tc    [svt_pkg::CORNERS];
   logic signed [svt_pkg::RT_W-1:0]   ts    [svt_pkg::CORNERS];
   logic signed [svt_pkg::SUM_W-1:0]  sum_x [svt_pkg::CORNERS];
   logic signed [svt_pkg::SUM_W-1:0]  sum_y [svt_pkg::CORNERS];
   logic [svt_pkg::OUT_W-1:0]         data_in;
   logic [svt_pkg::OUT_W-1:0]         data_ff;

   assign ofs_b[0] = side_b_ff.u0;
   assign ofs_b[1] = side_b_ff.u1;
   assign ofs_b[2] = side_b_ff.v0;
   assign ofs_b[3] = side_b_ff.v1;

   always_comb begin
      for (int k = 0; k < svt_pkg::CORNERS; k++) begin
         rnd_c[k] = {pc_ff[k][svt_pkg::PROD_W-1], pc_ff[k]} + svt_pkg::PROD_HALF;
         rnd_s[k] = {ps_ff[k][svt_pkg::PROD_W-1], ps_ff[k]} + svt_pkg::PROD_HALF;
         tc[k]    = rnd_c[k][svt_pkg::PROD_W:svt_pkg::TRIG_FRAC];
         ts[k]    = rnd_s[k][svt_pkg::PROD_W:svt_pkg::TRIG_FRAC];
      end
      // corner k uses u index k&1 and v index 2+(k>>1)
      for (int k = 0; k < svt_pkg::CORNERS; k++) begin
         if (side_b_ff.rot) begin
            sum_x[k] = svt_pkg::SUM_W'(side_b_ff.px) + svt_pkg::SUM_W'(tc[k & 1])
                     - svt_pkg::SUM_W'(ts[2 + (k >> 1)]);
            sum_y[k] = svt_pkg::SUM_W'(side_b_ff.py) + svt_pkg::SUM_W'(tc[2 + (k >> 1)])
                     + svt_pkg::SUM_W'(ts[k & 1]);
         end else begin
            sum_x[k] = svt_pkg::SUM_W'(side_b_ff.px) + svt_pkg::SUM_W'(ofs_b[k & 1]);
            sum_y[k] = svt_pkg::SUM_W'(side_b_ff.py) + svt_pkg::SUM_W'(ofs_b[2 + (k >> 1)]);
         end
         data_in[2*k*svt_pkg::POS_W +: svt_pkg::POS_W]     = svt_pkg::sat_pos(sum_x[k]);
         data_in[(2*k+1)*svt_pkg::POS_W +: svt_pkg::POS_W] = svt_pkg::sat_pos(sum_y[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = v_ff[2];
   assign out_data  = data_ff;

   // rounded cos and sin never exceed one by more than the cordic gain error
   `SVT_ASSERT(a_cos_range, clock, reset, v_ff[0] |-> (c_ff <= 17'sd16400) && (c_ff >= -17'sd16400), "cos out of range")
   `SVT_ASSERT(a_sin_range, clock, reset, v_ff[0] |-> (s_ff <= 17'sd16400) && (s_ff >= -17'sd16400), "sin out of range")
   // an empty first stage always takes a word
   `SVT_ASSERT(a_empty_ready, clock, reset, !v_ff[0] |-> in_ready, "empty stage stalled")

endmodule

// ----- src/sprite_quad_vertex_transform.sv -----
// ----------------------------------------------------------------------------
// sprite_quad_vertex_transform
// four corner points of an anchored sprite quad: move, scale or scale+rotate
// ----------------------------------------------------------------------------
// a request passes the prep, cordic and rotate stages from req accept to rsp_tvalid
// throughput: one word per cycle while rsp_tready does not stall it, one cordic iteration per stage
// stalls back up stage by stage, empty stages keep taking words
// reset clears all valid bits and the size and anchor registers to zero
`include "sprite_quad_vertex_transform_macros.svh"

module sprite_quad_vertex_transform #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // register write port
   input  logic                               csr_we,
   input  logic [svt_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [svt_pkg::SIZE_W-1:0]         csr_wdata,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [95:0]                        req_tdata,  // pos_x, pos_y, scale_x, scale_y, angle
   input  logic [svt_pkg::ACT_W-1:0]          req_tuser,  // action
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [svt_pkg::OUT_W-1:0]          rsp_tdata   // corner0_x, corner0_y, corner1_x,
                                                          // corner1_y, corner2_x, corner2_y,
                                                          // corner3_x, corner3_y
);

   // prep to cordic
   logic                              pc_valid, pc_ready, pc_flip;
   svt_pkg::svt_side_type             pc_side;
   logic signed [svt_pkg::CORD_W-1:0] pc_z;

   // cordic to rotate
   logic                              cr_valid, cr_ready, cr_flip;
   svt_pkg::svt_side_type             cr_side;
   logic signed [svt_pkg::CORD_W-1:0] cr_x, cr_y;

   svt_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_action  (req_tuser),
      .in_pos_x   ($signed(req_tdata[23:0])),
      .in_pos_y   ($signed(req_tdata[47:24])),
      .in_scale_x ($signed(req_tdata[63:48])),
      .in_scale_y ($signed(req_tdata[79:64])),
      .in_angle   (req_tdata[95:80]),
      .out_valid  (pc_valid),
      .out_ready  (pc_ready),
      .out_side   (pc_side),
      .out_z      (pc_z),
      .out_flip   (pc_flip)
   );

   svt_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pc_valid),
      .in_ready  (pc_ready),
      .in_side   (pc_side),
      .in_z      (pc_z),
      .in_flip   (pc_flip),
      .out_valid (cr_valid),
      .out_ready (cr_ready),
      .out_side  (cr_side),
      .out_x     (cr_x),
      .out_y     (cr_y),
      .out_flip  (cr_flip)
   );

   svt_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cr_valid),
      .in_ready  (cr_ready),
      .in_side   (cr_side),
      .in_x      (cr_x),
      .in_y      (cr_y),
      .in_flip   (cr_flip),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // no result shows right after reset
   `SVT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

// ----- bench/tb_sprite_quad_vertex_transform.sv -----
// ----------------------------------------------------------------------------
// tb_sprite_quad_vertex_transform
// self-checking bench for the sprite quad corner transform: a queue-fed
// driver offers request words, a bit-accurate corner predictor (fixed point
// cordic included) computes each quad at acceptance, and the response monitor
// compares every corner coordinate in order under random stalls on both sides
// ----------------------------------------------------------------------------
module tb_sprite_quad_vertex_transform;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CORDIC_STEPS   = 16;
   localparam int FRAC_BITS      = 8;
   localparam int LATENCY        = CORDIC_STEPS + 5;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 200;
   localparam int RANDOM_PHASES  = 9;
   localparam int PHASE_WORDS    = 150;

   // spare codes that the block folds onto defaults
   localparam logic [svt_pkg::ACT_W-1:0]  ACT_SPARE  = 2'd3;
   localparam logic [svt_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

   // cordic start value and rounding shifts of the corner math
   localparam longint INV_GAIN   = 64'sd652032874;
   localparam int     TRIG_SHIFT = 16;
   localparam int     PROD_SHIFT = 14;

   // arctangent of 2^-i in 2^-32 turn units, entry 0 in the low bits
   localparam logic [16*32-1:0] ATAN_TURNS = {
      32'h0000517C, 32'h0000A2F9, 32'h000145F3, 32'h00028BE6,
      32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
      32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
      32'h051111D4, 32'h09FB385B, 32'h12E4051D, 32'h20000000
   };

   typedef struct packed {
      logic [svt_pkg::ACT_W-1:0]          action;
      logic signed [svt_pkg::POS_W-1:0]   pos_x;
      logic signed [svt_pkg::POS_W-1:0]   pos_y;
      logic signed [svt_pkg::SCALE_W-1:0] scale_x;
      logic signed [svt_pkg::SCALE_W-1:0] scale_y;
      logic [svt_pkg::ANGLE_W-1:0]        angle;
   } sprite_item_type;

   // dut connections
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [svt_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [svt_pkg::SIZE_W-1:0]     csr_wdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [95:0]                    req_tdata = '0;   // pos_x, pos_y, scale_x, scale_y, angle
   logic [svt_pkg::ACT_W-1:0]      req_tuser = '0;   // action
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [svt_pkg::OUT_W-1:0]      rsp_tdata;        // corner0_x, corner0_y, ... corner3_y

   // shadow copy of the sprite registers
   logic [svt_pkg::SIZE_W-1:0] cfg_width  = '0;
   logic [svt_pkg::SIZE_W-1:0] cfg_height = '0;
   logic [svt_pkg::MODE_W-1:0] cfg_xmode  = '0;
   logic [svt_pkg::MODE_W-1:0] cfg_ymode  = '0;

   // traffic bookkeeping
   sprite_item_type           pending_items [$];
   logic [svt_pkg::OUT_W-1:0] expected_quads [$];
   sprite_item_type           cur_item;
   int                        queued_total = 0;
   int                        accept_count = 0;
   int                        mismatch_count = 0;
   int                        send_gap = 0;
   int                        recv_gap = 0;
   int                        hold_left = 0;
   int                        quiet_cycles = 0;
   bit                        idle_on = 1'b1;
   bit                        long_hold_req = 1'b0;
   bit                        long_hold_done = 1'b0;

   sprite_quad_vertex_transform #(
      .CORDIC_STEPS(CORDIC_STEPS),
      .FRAC_BITS   (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // anchor offset inside the sprite, spare mode falls back to zero
   function automatic longint anchor_offset(input logic [svt_pkg::SIZE_W-1:0] size,
                                            input logic [svt_pkg::MODE_W-1:0] mode);
      if (mode == svt_pkg::MODE_CENTER) begin
         return longint'(size >> 1);
      end else if (mode == svt_pkg::MODE_END) begin
         return longint'(size);
      end
      return 0;
   endfunction

   // clamp to signed 24 bit coordinate range
   function automatic logic [svt_pkg::POS_W-1:0] clamp_coord(input longint v);
      if (v > 64'sd8388607) begin
         return 24'h7FFFFF;
      end else if (v < -64'sd8388608) begin
         return 24'h800000;
      end
      return v[svt_pkg::POS_W-1:0];
   endfunction

   // four corners of the quad for one request under the current registers
   function automatic logic [svt_pkg::OUT_W-1:0] transform_quad(input sprite_item_type it);
      logic [svt_pkg::OUT_W-1:0] quad;
      longint                    ofs_u [2];
      longint                    ofs_v [2];
      longint                    ax, ay, px, py, cosv, sinv;
      longint                    x, y, z, dx, dy, cx, cy, uu, vv;
      logic [31:0]               turn;
      logic                      flip;
      ax = anchor_offset(cfg_width, cfg_xmode);
      ay = anchor_offset(cfg_height, cfg_ymode);
      ofs_u[0] = -ax;
      ofs_u[1] = longint'(cfg_width) - ax;
      ofs_v[0] = -ay;
      ofs_v[1] = longint'(cfg_height) - ay;
      px = longint'(it.pos_x);
      py = longint'(it.pos_y);
      cosv = 0;
      sinv = 0;

      // scaled offsets carry the scale's fraction, plain ones are shifted up
      for (int e = 0; e < 2; e++) begin
         if (it.action == svt_pkg::ACT_SCALE || it.action == svt_pkg::ACT_ROTATE) begin
            ofs_u[e] = ofs_u[e] * longint'(it.scale_x);
            ofs_v[e] = ofs_v[e] * longint'(it.scale_y);
         end else begin
            ofs_u[e] = ofs_u[e] * (longint'(1) << FRAC_BITS);
            ofs_v[e] = ofs_v[e] * (longint'(1) << FRAC_BITS);
         end
      end

      // cordic sine and cosine, angle folded into the right half plane
      if (it.action == svt_pkg::ACT_ROTATE) begin
         turn = {it.angle, 16'h0000};
         flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
         if (flip) begin
            turn = turn - 32'h80000000;
         end
         z = longint'($signed(turn));
         x = INV_GAIN;
         y = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - longint'(ATAN_TURNS[i*32 +: 32]);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + longint'(ATAN_TURNS[i*32 +: 32]);
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         cosv = (x + (longint'(1) << (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
         sinv = (y + (longint'(1) << (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
      end

      for (int k = 0; k < svt_pkg::CORNERS; k++) begin
         uu = ofs_u[k % 2];
         vv = ofs_v[k / 2];
         if (it.action == svt_pkg::ACT_ROTATE) begin
            cx = px + ((uu * cosv + (longint'(1) << (PROD_SHIFT - 1))) >>> PROD_SHIFT)
                    - ((vv * sinv + (longint'(1) << (PROD_SHIFT - 1))) >>> PROD_SHIFT);
            cy = py + ((vv * cosv + (longint'(1) << (PROD_SHIFT - 1))) >>> PROD_SHIFT)
                    + ((uu * sinv + (longint'(1) << (PROD_SHIFT - 1))) >>> PROD_SHIFT);
         end else begin
            cx = px + uu;
            cy = py + vv;
         end
         quad[k*2*svt_pkg::POS_W +: svt_pkg::POS_W]                  = clamp_coord(cx);
         quad[k*2*svt_pkg::POS_W + svt_pkg::POS_W +: svt_pkg::POS_W] = clamp_coord(cy);
      end
      return quad;
   endfunction

   // random request, biased toward extremes and quadrant edges
   function automatic sprite_item_type random_item();
      sprite_item_type it;
      int              pick;
      it.action = ($urandom_range(0, 15) == 0) ? ACT_SPARE
                                               : svt_pkg::ACT_W'($urandom_range(0, 2));
      it.angle = svt_pkg::ANGLE_W'($urandom);
      if ($urandom_range(0, 5) == 0) begin
         it.angle = svt_pkg::ANGLE_W'(16'h4000 * $urandom_range(0, 3)
                                      + $urandom_range(0, 2) - 1);
      end
      pick = $urandom_range(0, 3);
      case (pick)
         0: begin
            it.pos_x = svt_pkg::POS_W'(int'($urandom_range(0, 400000)) - 200000);
            it.pos_y = svt_pkg::POS_W'(int'($urandom_range(0, 400000)) - 200000);
         end
         1: begin
            it.pos_x = $urandom_range(0, 1)
                     ? svt_pkg::POS_W'(24'sh7FFFFF - $urandom_range(0, 3)) : 24'sh800000;
            it.pos_y = $urandom_range(0, 1)
                     ? svt_pkg::POS_W'(24'sh800000 + $urandom_range(0, 3)) : 24'sh7FFFFF;
         end
         default: begin
            it.pos_x = svt_pkg::POS_W'($urandom);
            it.pos_y = svt_pkg::POS_W'($urandom);
         end
      endcase
      pick = $urandom_range(0, 3);
      case (pick)
         0: begin
            it.scale_x = svt_pkg::SCALE_W'(256 + int'($urandom_range(0, 64)) - 32);
            it.scale_y = svt_pkg::SCALE_W'(256 + int'($urandom_range(0, 64)) - 32);
         end
         1: begin
            it.scale_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            it.scale_y = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
         end
         2: begin
            it.scale_x = svt_pkg::SCALE_W'(int'($urandom_range(0, 2048)) - 1024);
            it.scale_y = svt_pkg::SCALE_W'(int'($urandom_range(0, 2048)) - 1024);
         end
         default: begin
            it.scale_x = svt_pkg::SCALE_W'($urandom);
            it.scale_y = svt_pkg::SCALE_W'($urandom);
         end
      endcase
      return it;
   endfunction

   task automatic queue_item(input logic [svt_pkg::ACT_W-1:0] act, input int px, input int py,
                             input int sx, input int sy,
                             input logic [svt_pkg::ANGLE_W-1:0] ang);
      sprite_item_type it;
      it.action  = act;
      it.pos_x   = svt_pkg::POS_W'(px);
      it.pos_y   = svt_pkg::POS_W'(py);
      it.scale_x = svt_pkg::SCALE_W'(sx);
      it.scale_y = svt_pkg::SCALE_W'(sy);
      it.angle   = ang;
      pending_items.push_back(it);
      queued_total++;
   endtask

   task automatic queue_random(input int count);
      repeat (count) begin
         pending_items.push_back(random_item());
         queued_total++;
      end
   endtask

   // one register write, shadow copy follows
   task automatic write_csr(input logic [svt_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [svt_pkg::SIZE_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (addr)
         svt_pkg::CSR_WIDTH:  cfg_width  = data;
         svt_pkg::CSR_HEIGHT: cfg_height = data;
         svt_pkg::CSR_XMODE:  cfg_xmode  = data[svt_pkg::MODE_W-1:0];
         default:             cfg_ymode  = data[svt_pkg::MODE_W-1:0];
      endcase
   endtask

   task automatic load_sprite_config(input logic [svt_pkg::SIZE_W-1:0] w,
                                     input logic [svt_pkg::SIZE_W-1:0] h,
                                     input logic [svt_pkg::MODE_W-1:0] xm,
                                     input logic [svt_pkg::MODE_W-1:0] ym);
      write_csr(svt_pkg::CSR_WIDTH, w);
      write_csr(svt_pkg::CSR_HEIGHT, h);
      write_csr(svt_pkg::CSR_XMODE, svt_pkg::SIZE_W'(xm));
      write_csr(svt_pkg::CSR_YMODE, svt_pkg::SIZE_W'(ym));
   endtask

   // wait for every queued word to be taken and every quad to come back
   task automatic drain();
      while (accept_count != queued_total || expected_quads.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_quads.push_back(transform_quad(cur_item));
            accept_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               cur_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_item.angle, cur_item.scale_y, cur_item.scale_x,
                              cur_item.pos_y, cur_item.pos_x};
               req_tuser  <= cur_item.action;
               if (idle_on && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 11);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and backpressure
   always @(posedge clock) begin
      logic [svt_pkg::OUT_W-1:0]        want;
      logic signed [svt_pkg::POS_W-1:0] got_f;
      logic signed [svt_pkg::POS_W-1:0] want_f;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_quads.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected quad word %h", rsp_tdata);
               end
            end else begin
               want = expected_quads.pop_front();
               for (int f = 0; f < 2 * svt_pkg::CORNERS; f++) begin
                  got_f  = rsp_tdata[f*svt_pkg::POS_W +: svt_pkg::POS_W];
                  want_f = want[f*svt_pkg::POS_W +: svt_pkg::POS_W];
                  if (got_f !== want_f) begin
                     mismatch_count++;
                     if (mismatch_count <= 10) begin
                        $display("corner%0d_%s mismatch: expected %0d, got %0d",
                                 f / 2, (f % 2) ? "y" : "x", want_f, got_f);
                     end
                  end
               end
            end
         end

         // one long hold-off so the pipeline fills and stalls its input
         if (long_hold_req && !long_hold_done) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) begin
               recv_gap = $urandom_range(1, 11);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sprite_quad_vertex_transform test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      logic [svt_pkg::SIZE_W-1:0] w, h;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // registers at reset values: zero-size sprite, field extremes
      queue_item(svt_pkg::ACT_MOVE, 8388607, -8388608, 0, 0, 16'h0000);
      queue_item(ACT_SPARE, -8388608, 8388607, -32768, 32767, 16'hFFFF);
      drain();

      // largest sprite anchored bottom-right, every action, saturation
      load_sprite_config(12'd4095, 12'd4095, svt_pkg::MODE_END, svt_pkg::MODE_END);
      queue_item(svt_pkg::ACT_MOVE, 0, 0, 256, 256, 16'h0000);
      queue_item(svt_pkg::ACT_MOVE, -8388608, -8388608, 0, 0, 16'h0000);
      queue_item(svt_pkg::ACT_SCALE, 0, 0, 32767, 32767, 16'h1234);
      queue_item(svt_pkg::ACT_SCALE, 8388607, 8388607, -32768, -32768, 16'h0000);
      queue_item(svt_pkg::ACT_SCALE, 1000, 2000, 256, 256, 16'h0000);
      queue_item(svt_pkg::ACT_SCALE, 5, -5, 0, 0, 16'h0000);
      queue_item(svt_pkg::ACT_ROTATE, 0, 0, 256, 256, 16'h0000);
      queue_item(svt_pkg::ACT_ROTATE, 0, 0, 256, 256, 16'h4000);
      queue_item(svt_pkg::ACT_ROTATE, 0, 0, 256, 256, 16'h8000);
      queue_item(svt_pkg::ACT_ROTATE, 0, 0, 256, 256, 16'hC000);
      queue_item(svt_pkg::ACT_ROTATE, 8388607, -8388608, 32767, -32768, 16'hFFFF);
      drain();

      // odd-size centered sprite: floor of half size, quadrant boundaries
      load_sprite_config(12'd63, 12'd33, svt_pkg::MODE_CENTER, svt_pkg::MODE_CENTER);
      queue_item(svt_pkg::ACT_MOVE, 1000, -1000, 0, 0, 16'h0000);
      queue_item(svt_pkg::ACT_ROTATE, 300, 400, 256, -256, 16'h3FFF);
      queue_item(svt_pkg::ACT_ROTATE, -300, 400, 256, 256, 16'h4001);
      queue_item(svt_pkg::ACT_ROTATE, 300, -400, 384, 256, 16'hBFFF);
      queue_item(svt_pkg::ACT_ROTATE, 0, 0, -128, 512, 16'h2000);
      queue_item(ACT_SPARE, 77, 88, 512, 512, 16'h0100);
      drain();

      // spare anchor modes behave like start anchoring
      load_sprite_config(12'd1, 12'd4095, MODE_SPARE, MODE_SPARE);
      queue_item(svt_pkg::ACT_MOVE, -12345, 54321, 0, 0, 16'h0000);
      queue_item(svt_pkg::ACT_SCALE, 0, 0, -1, 1, 16'h0000);
      queue_item(svt_pkg::ACT_ROTATE, 100, 100, 300, 300, 16'h6000);
      queue_item(svt_pkg::ACT_ROTATE, -100, -100, 300, -300, 16'hE000);
      drain();

      // random phases with random sprite settings, extremes now and then
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         w = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                                         : svt_pkg::SIZE_W'($urandom);
         h = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 12'd4095 : 12'd0)
                                         : svt_pkg::SIZE_W'($urandom);
         load_sprite_config(w, h, svt_pkg::MODE_W'($urandom_range(0, 3)),
                            svt_pkg::MODE_W'($urandom_range(0, 3)));
         idle_on = (ph == RANDOM_PHASES - 1) ? 1'b0 : (ph % 3 != 2);
         queue_random(PHASE_WORDS);
         if (ph == 4) begin
            long_hold_req = 1'b1;
         end
         drain();
      end

      if (mismatch_count == 0 && expected_quads.size() == 0) begin
         $display("sprite_quad_vertex_transform test passed");
      end else begin
         $display("sprite_quad_vertex_transform test failed");
      end
      $finish;
   end

endmodule
